### rtl/ipid_pkg.sv
// Shared types and constants of the incremental PID H-bridge duty block.
// Field widths, register reset values and configuration register indexes.
// No dependencies; compile first.
package ipid_pkg;

  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 12;
  localparam int DUTY_W  = 8;
  localparam int CFG_W   = 12;

  // Drive accumulator holds plus or minus a full duty magnitude.
  localparam int ACC_W   = DUTY_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET     = 12'd128;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET     = 12'd64;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET     = 12'd0;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 8'd80;

  typedef enum logic [1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_I     = 2'd1,
    REG_GAIN_D     = 2'd2,
    REG_DUTY_LIMIT = 2'd3
  } cfg_reg_t;

endpackage

### rtl/ipid_in_if.sv
// Request channel of the incremental PID block: valid/ready plus speeds.
// Depends on ipid_pkg for field widths.
interface ipid_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ipid_pkg::SPEED_W-1:0] target_speed;
  logic signed [ipid_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

### rtl/ipid_out_if.sv
// Result channel of the incremental PID block: valid/ready plus both duties.
// Depends on ipid_pkg for field widths.
interface ipid_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipid_pkg::DUTY_W-1:0]  forward_duty;
  logic [ipid_pkg::DUTY_W-1:0]  reverse_duty;

  modport source (output valid, output forward_duty, output reverse_duty, input ready);
  modport sink   (input valid, input forward_duty, input reverse_duty, output ready);
endinterface

### rtl/incremental_pid_hbridge_duty_core.sv
// Incremental PID speed controller for an H-bridge. A request (target and
// measured speed) lands in an input register; as it advances, the block
// forms the new error, the P, I and D increments (gains unsigned Q4.8,
// truncated toward zero), adds them to the signed drive accumulator, clamps
// to +-duty_limit and registers the split forward/reverse duty. One
// request is taken every cycle unless the output stalls; the accumulator
// updates with the result, so back-to-back requests see each other's state.
// Depends on ipid_pkg, ipid_in_if and ipid_out_if.
module incremental_pid_hbridge_duty_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  ipid_pkg::cfg_reg_t      cfg_index,
  input  logic [ipid_pkg::CFG_W-1:0] cfg_wdata,
  ipid_in_if.sink                 in_req,
  ipid_out_if.source              out_rsp
);
  import ipid_pkg::*;

  localparam int PROD_W = 32;
  localparam int INC_W  = PROD_W - 8;
  localparam int SUM_W  = INC_W + 2;

  // gain times x over 256, toward zero
  function automatic logic signed [INC_W-1:0] trunc_q48(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] biased;
    biased = prod + (prod[PROD_W-1] ? 32'sd255 : 32'sd0);
    return signed'(biased[PROD_W-1:8]);
  endfunction

  // configuration
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [DUTY_W-1:0] duty_limit_r;

  // input stage
  logic                      s1_valid_r;
  logic [SPEED_W-1:0]        s1_target_r;
  logic [SPEED_W-1:0]        s1_measured_r;

  // controller state
  logic [SPEED_W-1:0]        err0_r, err1_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  // result stage
  logic                      out_valid_r;
  logic [DUTY_W-1:0]         fwd_r, rev_r, fwd_nxt, rev_nxt;

  logic in_fire, s1_adv;

  logic [SPEED_W-1:0]        err_new;
  logic signed [SPEED_W:0]   diff_p;
  logic signed [SPEED_W+1:0] diff_d;
  logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;
  logic signed [INC_W-1:0]   inc_p, inc_i, inc_d;
  logic signed [SUM_W-1:0]   sum, lim_pos, lim_neg;
  logic signed [ACC_W-1:0]   acc_neg;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_fire      = in_req.valid && in_req.ready;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.forward_duty = fwd_r;
  assign out_rsp.reverse_duty = rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= GAIN_P_RESET;
      gain_i_r     <= GAIN_I_RESET;
      gain_d_r     <= GAIN_D_RESET;
      duty_limit_r <= DUTY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:     gain_p_r     <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_r     <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_r     <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_LIMIT: duty_limit_r <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // error wraps to 16 bits
    err_new = s1_target_r - s1_measured_r;
    diff_p  = $signed({err_new[SPEED_W-1], err_new}) - $signed({err0_r[SPEED_W-1], err0_r});
    diff_d  = $signed({{2{err_new[SPEED_W-1]}}, err_new})
            - $signed({err0_r[SPEED_W-1], err0_r, 1'b0})
            + $signed({{2{err1_r[SPEED_W-1]}}, err1_r});

    prod_p = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_p_r})
           * $signed({{(PROD_W-SPEED_W-1){diff_p[SPEED_W]}}, diff_p});
    prod_i = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_i_r})
           * $signed({{(PROD_W-SPEED_W){err_new[SPEED_W-1]}}, err_new});
    prod_d = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_d_r})
           * $signed({{(PROD_W-SPEED_W-2){diff_d[SPEED_W+1]}}, diff_d});

    inc_p = trunc_q48(prod_p);
    inc_i = trunc_q48(prod_i);
    inc_d = trunc_q48(prod_d);

    sum = $signed({{(SUM_W-ACC_W){acc_r[ACC_W-1]}}, acc_r})
        + $signed({{2{inc_p[INC_W-1]}}, inc_p})
        + $signed({{2{inc_i[INC_W-1]}}, inc_i})
        + $signed({{2{inc_d[INC_W-1]}}, inc_d});

    lim_pos = $signed({{(SUM_W-DUTY_W){1'b0}}, duty_limit_r});
    lim_neg = -lim_pos;

    if (sum > lim_pos) begin
      acc_nxt = lim_pos[ACC_W-1:0];
    end else if (sum < lim_neg) begin
      acc_nxt = lim_neg[ACC_W-1:0];
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end

    acc_neg = -acc_nxt;
    fwd_nxt = '0;
    rev_nxt = '0;
    if (acc_nxt[ACC_W-1]) begin
      rev_nxt = acc_neg[DUTY_W-1:0];
    end else begin
      fwd_nxt = acc_nxt[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err0_r      <= '0;
      err1_r      <= '0;
      acc_r       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        err0_r      <= err_new;
        err1_r      <= err0_r;
        acc_r       <= acc_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_target_r   <= in_req.target_speed;
      s1_measured_r <= in_req.measured_speed;
    end
    if (s1_adv) begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
    end
  end

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("processed request did not produce a result");

  a_acc_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(acc_r) && $stable(err0_r) && $stable(err1_r))
    else $error("controller state changed without a request");

  a_duty_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (acc_r[ACC_W-1] ? (fwd_r == '0 && rev_r == DUTY_W'(-acc_r))
                                     : (rev_r == '0 && fwd_r == acc_r[DUTY_W-1:0])))
    else $error("duty outputs disagree with drive accumulator");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_rsp.ready) |-> !in_req.ready)
    else $error("request taken while both stages are full");

endmodule
